[src/assert_macros.svh]
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SVA_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define SVA_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SVA_IMPLIES(label, clk, rst_n, ante, cons)
`define SVA_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/sva_pkg.sv]
`default_nettype none

package sva_pkg;

  localparam int NUM_VOICES = 9;
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int VOICE_W    = 4;
  localparam int CHAN_W     = 4;
  localparam int SRC_W      = 4;
  localparam int MASK_W     = 9;
  localparam int MC_W       = 4;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [MC_W-1:0] MC_RESET = MC_W'(6);

  // register index taken from paddr[2]
  localparam logic REG_MELODIC_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_RELEASE  = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [CHAN_W-1:0]  midi_channel;
    logic [SRC_W-1:0]   source;
    logic [VOICE_W-1:0] voice_in;
  } in_item_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic               key_off;
    logic [MASK_W-1:0]  freed_mask;
  } out_item_t;

  typedef struct packed {
    logic load;    // capture the input beat
    logic commit;  // update the voice table and load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [VIDX_W-1:0] lowest_idx(input logic [NUM_VOICES-1:0] vec);
    logic [VIDX_W-1:0] idx;
    idx = '0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (vec[v]) begin
        idx = VIDX_W'(v);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[src/synth_voice_allocator.sv]
// Channel   Dir  Handshake              Payload
// in        in   in_valid_i/in_ready_o  in_data_i  (cmd, midi_channel, source, voice_in)
// out       out  out_valid_o/out_ready_i out_data_o (voice, key_off, freed_mask)
// cfg       in   APB psel/penable/pwrite paddr/pwdata/prdata (melodic_count at 0x0)
//
// Each beat is captured in the idle state; the execute state then scans the voice table
// with priority encoders and commits the table update and the result.
// The result register holds one beat; while it is full and not taken, the
// commit waits and in_ready_o stays low.
// Reset clears the voice table and sets melodic_count to 6.
`default_nettype none

`include "assert_macros.svh"

module synth_voice_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire sva_pkg::in_item_t               in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output sva_pkg::out_item_t                   out_data_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sva_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [sva_pkg::PDATA_W-1:0]     pwdata,
  output logic [sva_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  sva_pkg::ctrl_cmd_t        cmd;
  sva_pkg::dp_stat_t         stat;
  logic                      cfg_we;
  logic [sva_pkg::MC_W-1:0]  mc;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == sva_pkg::REG_MELODIC_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr[2] == sva_pkg::REG_MELODIC_COUNT) begin
      prdata = sva_pkg::PDATA_W'(mc);
    end
  end

  sva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  sva_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_data_i       (in_data_i),
    .out_ready_i     (out_ready_i),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (pwdata[sva_pkg::MC_W-1:0]),
    .melodic_count_o (mc),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_data_o      (out_data_o)
  );

  // one beat in flight: busy the cycle after an accept
  `SVA_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // a new result is only loaded from the execute step
  `SVA_IMPLIES(a_result_from_exec, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o))

  // a release result never carries an allocate's fields
  `SVA_IMPLIES(a_release_clean, clk_i, rst_ni,
               out_valid_o && (out_data_o.freed_mask != '0),
               (out_data_o.voice == '0) && !out_data_o.key_off)

endmodule

`default_nettype wire

[src/sva_ctrl.sv]
`default_nettype none

module sva_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 out_ready_i,
  input  wire sva_pkg::dp_stat_t    stat_i,
  output logic                      in_ready_o,
  output sva_pkg::ctrl_cmd_t        cmd_o
);

  sva_pkg::state_e state_q, state_d;
  logic            can_commit;

  // result register is free, or its beat leaves this cycle
  assign can_commit = !stat_i.out_full || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sva_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sva_pkg::ST_EXEC;
        end
      end
      sva_pkg::ST_EXEC: begin
        if (can_commit) begin
          state_d = sva_pkg::ST_IDLE;
        end
      end
      default: state_d = sva_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      sva_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sva_pkg::ST_EXEC: begin
        cmd_o.commit = can_commit;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sva_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/sva_datapath.sv]
`default_nettype none

module sva_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sva_pkg::ctrl_cmd_t           cmd_i,
  input  wire sva_pkg::in_item_t            in_data_i,
  input  wire logic                         out_ready_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [sva_pkg::MC_W-1:0]     cfg_wdata_i,
  output logic [sva_pkg::MC_W-1:0]          melodic_count_o,
  output sva_pkg::dp_stat_t                 stat_o,
  output logic                              out_valid_o,
  output sva_pkg::out_item_t                out_data_o
);

  localparam int NV = sva_pkg::NUM_VOICES;

  logic [sva_pkg::MC_W-1:0] mc_q;

  sva_pkg::in_item_t  item_q;
  sva_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [NV-1:0]                   alloc_q, alloc_d;
  logic [NV-1:0]                   play_q, play_d;
  logic [sva_pkg::CHAN_W-1:0]      chan_q [NV];
  logic [sva_pkg::CHAN_W-1:0]      chan_d [NV];
  logic [sva_pkg::SRC_W-1:0]       src_q [NV];
  logic [sva_pkg::SRC_W-1:0]       src_d [NV];

  logic [NV-1:0]                   in_scan, match, free_v, idle_v, pick_sel;
  logic [sva_pkg::VIDX_W-1:0]      pick;

  // scan flags over voices 0..melodic_count-1 (saturates at the table size)
  always_comb begin
    for (int v = 0; v < NV; v++) begin
      in_scan[v] = (v < int'(mc_q));
      match[v]   = in_scan[v] && alloc_q[v] && !play_q[v] &&
                   (chan_q[v] == item_q.midi_channel) && (src_q[v] == item_q.source);
      free_v[v]  = in_scan[v] && !alloc_q[v];
      idle_v[v]  = in_scan[v] && !play_q[v];
    end
  end

  always_comb begin
    if (|match) begin
      pick = sva_pkg::lowest_idx(match);
    end else if (|free_v) begin
      pick = sva_pkg::lowest_idx(free_v);
    end else if (|idle_v) begin
      pick = sva_pkg::lowest_idx(idle_v);
    end else begin
      pick = '0;  // steal voice 0
    end
    for (int v = 0; v < NV; v++) begin
      pick_sel[v] = (int'(pick) == v);
    end
  end

  always_comb begin
    alloc_d = alloc_q;
    play_d  = play_q;
    chan_d  = chan_q;
    src_d   = src_q;
    out_d   = '0;
    case (item_q.cmd)
      sva_pkg::CMD_ALLOC: begin
        out_d.voice   = sva_pkg::VOICE_W'(pick);
        out_d.key_off = |(play_q & pick_sel);
        for (int v = 0; v < NV; v++) begin
          if (pick_sel[v]) begin
            play_d[v]  = 1'b0;
            alloc_d[v] = 1'b1;
            chan_d[v]  = item_q.midi_channel;
            src_d[v]   = item_q.source;
          end
        end
      end
      sva_pkg::CMD_NOTE_ON, sva_pkg::CMD_NOTE_OFF: begin
        for (int v = 0; v < NV; v++) begin
          if (int'(item_q.voice_in) == v) begin
            play_d[v] = (item_q.cmd == sva_pkg::CMD_NOTE_ON);
          end
        end
      end
      sva_pkg::CMD_RELEASE: begin
        for (int v = 0; v < NV; v++) begin
          if (match[v]) begin
            alloc_d[v] = 1'b0;
          end
        end
        // mask carries one bit per voice
        for (int b = 0; b < sva_pkg::MASK_W; b++) begin
          if (b < NV) begin
            out_d.freed_mask[b] = match[b];
          end
        end
      end
      default: out_d = '0;
    endcase
  end

  assign out_valid_d = cmd_i.commit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q        <= sva_pkg::MC_RESET;
      out_valid_q <= 1'b0;
      alloc_q     <= '0;
      play_q      <= '0;
      for (int v = 0; v < NV; v++) begin
        chan_q[v] <= '0;
        src_q[v]  <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mc_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        alloc_q <= alloc_d;
        play_q  <= play_d;
        chan_q  <= chan_d;
        src_q   <= src_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign melodic_count_o = mc_q;
  assign stat_o.out_full = out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

`default_nettype wire

[verif/synth_voice_allocator_tb.sv]
`timescale 1ns / 100ps

module synth_voice_allocator_tb;

  localparam logic [sva_pkg::PADDR_W-1:0] MC_ADDR = {sva_pkg::REG_MELODIC_COUNT, 2'b00};
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_BEATS = 228;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sva_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  sva_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sva_pkg::PADDR_W-1:0] paddr;
  logic [sva_pkg::PDATA_W-1:0] pwdata;
  logic [sva_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // shadow voice table and scan register
  bit voice_claimed [sva_pkg::NUM_VOICES];
  bit voice_sounding [sva_pkg::NUM_VOICES];
  logic [sva_pkg::CHAN_W-1:0] voice_chan [sva_pkg::NUM_VOICES];
  logic [sva_pkg::SRC_W-1:0] voice_src [sva_pkg::NUM_VOICES];
  logic [sva_pkg::MC_W-1:0] scan_count;

  sva_pkg::out_item_t pending_voice_results[$];
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned out_stall;
  int unsigned stall_draw;
  bit gaps_on;

  // scan counts per random phase: extremes, saturation and zero included
  logic [sva_pkg::MC_W-1:0] phase_counts [8] = '{4'd15, 4'd9, 4'd1, 4'd0, 4'd6, 4'd3, 4'd12, 4'd8};

  synth_voice_allocator i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocation policy: same owner idle, then free, then idle, then steal voice 0
  function automatic sva_pkg::out_item_t predict_voice_event(sva_pkg::in_item_t it);
    sva_pkg::out_item_t r;
    int n;
    int pick;
    int free_v;
    int idle_v;
    r = '0;
    n = (scan_count > sva_pkg::NUM_VOICES) ? sva_pkg::NUM_VOICES : int'(scan_count);
    case (it.cmd)
      sva_pkg::CMD_ALLOC: begin
        pick = -1;
        free_v = -1;
        idle_v = -1;
        for (int v = 0; v < n && pick < 0; v++) begin
          if (voice_claimed[v] && !voice_sounding[v] && voice_chan[v] == it.midi_channel &&
              voice_src[v] == it.source) begin
            pick = v;
          end else begin
            if (!voice_claimed[v] && free_v < 0) free_v = v;
            if (!voice_sounding[v] && idle_v < 0) idle_v = v;
          end
        end
        if (pick < 0) pick = (free_v >= 0) ? free_v : ((idle_v >= 0) ? idle_v : 0);
        r.key_off = voice_sounding[pick];
        voice_sounding[pick] = 1'b0;
        voice_claimed[pick] = 1'b1;
        voice_chan[pick] = it.midi_channel;
        voice_src[pick] = it.source;
        r.voice = sva_pkg::VOICE_W'(pick);
      end
      sva_pkg::CMD_NOTE_ON, sva_pkg::CMD_NOTE_OFF: begin
        if (it.voice_in < sva_pkg::NUM_VOICES) begin
          voice_sounding[it.voice_in] = (it.cmd == sva_pkg::CMD_NOTE_ON);
        end
      end
      default: begin
        for (int v = 0; v < n; v++) begin
          if (voice_claimed[v] && !voice_sounding[v] && voice_chan[v] == it.midi_channel &&
              voice_src[v] == it.source) begin
            voice_claimed[v] = 1'b0;
            r.freed_mask[v] = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic sva_pkg::in_item_t beat(sva_pkg::cmd_e c, logic [3:0] ch,
                                             logic [3:0] src, logic [3:0] vin);
    sva_pkg::in_item_t it;
    it.cmd = c;
    it.midi_channel = ch;
    it.source = src;
    it.voice_in = vin;
    return it;
  endfunction

  task automatic send_beat(input sva_pkg::in_item_t it, output sva_pkg::out_item_t res);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    res = predict_voice_event(it);
    pending_voice_results.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_voice_results.size() != 0);
  endtask

  task automatic write_scan_count(input logic [sva_pkg::MC_W-1:0] value);
    wait_drained();
    repeat (3) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MC_ADDR;
    pwdata <= ($urandom() & ~32'hF) | sva_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    scan_count = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_scan_readback();
  endtask

  task automatic check_scan_readback();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MC_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sva_pkg::PDATA_W'(scan_count)) begin
      $display("%0t: melodic_count readback mismatch, expected %0d, actual %0d",
               $time, scan_count, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_register_reset();
    check_scan_readback();
  endtask

  task automatic test_directed_commands();
    sva_pkg::out_item_t res;
    logic [3:0] v;
    send_beat(beat(sva_pkg::CMD_ALLOC, 4'hF, 4'hF, 4'h0), res);
    send_beat(beat(sva_pkg::CMD_NOTE_ON, 4'h0, 4'h0, 4'h0), res);
    send_beat(beat(sva_pkg::CMD_ALLOC, 4'hF, 4'hF, 4'hF), res);
    send_beat(beat(sva_pkg::CMD_RELEASE, 4'hF, 4'hF, 4'h0), res);
    send_beat(beat(sva_pkg::CMD_ALLOC, 4'h0, 4'h0, 4'h8), res);
    send_beat(beat(sva_pkg::CMD_NOTE_ON, 4'hA, 4'h5, 4'h8), res);   // outside scan, inside table
    send_beat(beat(sva_pkg::CMD_NOTE_ON, 4'h0, 4'h0, 4'hF), res);   // out of range
    send_beat(beat(sva_pkg::CMD_NOTE_OFF, 4'h0, 4'h0, 4'h9), res);
    send_beat(beat(sva_pkg::CMD_NOTE_OFF, 4'h0, 4'h0, 4'h3), res);  // idle, unallocated voice
    send_beat(beat(sva_pkg::CMD_NOTE_ON, 4'h0, 4'h0, 4'h2), res);   // unallocated voice starts
    send_beat(beat(sva_pkg::CMD_ALLOC, 4'h0, 4'h0, 4'h0), res);     // reuses own idle voice
    // claim the rest and keep them sounding, then steal
    for (int i = 0; i < 5; i++) begin
      send_beat(beat(sva_pkg::CMD_ALLOC, 4'(i + 2), 4'(13 - i), 4'h0), res);
      v = res.voice;
      send_beat(beat(sva_pkg::CMD_NOTE_ON, 4'h0, 4'h0, v), res);
    end
    send_beat(beat(sva_pkg::CMD_ALLOC, 4'h7, 4'h7, 4'h0), res);
    send_beat(beat(sva_pkg::CMD_RELEASE, 4'h0, 4'h0, 4'h0), res);
  endtask

  task automatic test_scan_limits();
    sva_pkg::out_item_t res;
    write_scan_count(sva_pkg::MC_W'(0));
    send_beat(beat(sva_pkg::CMD_NOTE_ON, 4'h0, 4'h0, 4'h0), res);
    send_beat(beat(sva_pkg::CMD_ALLOC, 4'h3, 4'h4, 4'h0), res);
    send_beat(beat(sva_pkg::CMD_RELEASE, 4'h3, 4'h4, 4'h0), res);
    write_scan_count(sva_pkg::MC_W'(15));
    send_beat(beat(sva_pkg::CMD_RELEASE, 4'h7, 4'h7, 4'h0), res);
    send_beat(beat(sva_pkg::CMD_ALLOC, 4'h9, 4'h6, 4'h0), res);
    send_beat(beat(sva_pkg::CMD_NOTE_OFF, 4'h0, 4'h0, 4'h8), res);
    send_beat(beat(sva_pkg::CMD_ALLOC, 4'h9, 4'h6, 4'h0), res);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    sva_pkg::in_item_t it;
    sva_pkg::out_item_t res;
    int unsigned roll;
    logic [3:0] last_voice;
    last_voice = '0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (i == count / 2) wait_drained();
      roll = $urandom_range(0, 99);
      // a few owners recur so idle voices get reused and released
      it.midi_channel = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(14, 15));
      it.source = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 1));
      it.voice_in = 4'($urandom());
      if (roll < 40) begin
        it.cmd = sva_pkg::CMD_ALLOC;
      end else if (roll < 65) begin
        it.cmd = sva_pkg::CMD_NOTE_ON;
        if ($urandom_range(0, 3) != 0) it.voice_in = last_voice;
      end else if (roll < 85) begin
        it.cmd = sva_pkg::CMD_NOTE_OFF;
        it.voice_in = 4'($urandom_range(0, 8));
      end else if (roll < 95) begin
        it.cmd = sva_pkg::CMD_RELEASE;
      end else begin
        it.cmd = sva_pkg::cmd_e'($urandom_range(0, 3));
      end
      send_beat(it, res);
      if (it.cmd == sva_pkg::CMD_ALLOC) last_voice = res.voice;
    end
  endtask

  // result side: random stall per beat
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      stall_draw = gaps_on ? $urandom_range(0, 5) : 0;
      out_stall <= stall_draw;
      out_ready <= (stall_draw == 0);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= (out_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  sva_pkg::out_item_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_voice_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want = pending_voice_results.pop_front();
        if (out_data.voice !== want.voice) begin
          $display("%0t: voice mismatch, expected %0d, actual %0d",
                   $time, want.voice, out_data.voice);
          errors++;
        end
        if (out_data.key_off !== want.key_off) begin
          $display("%0t: key_off mismatch, expected %0b, actual %0b",
                   $time, want.key_off, out_data.key_off);
          errors++;
        end
        if (out_data.freed_mask !== want.freed_mask) begin
          $display("%0t: freed_mask mismatch, expected %09b, actual %09b",
                   $time, want.freed_mask, out_data.freed_mask);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_voice_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idle_cycles <= 0;
    errors = 0;
    gaps_on = 1'b1;
    scan_count = sva_pkg::MC_RESET;
    for (int v = 0; v < sva_pkg::NUM_VOICES; v++) begin
      voice_claimed[v] = 1'b0;
      voice_sounding[v] = 1'b0;
      voice_chan[v] = '0;
      voice_src[v] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_directed_commands();
    test_scan_limits();
    foreach (phase_counts[p]) begin
      write_scan_count(phase_counts[p]);
      test_random_traffic(PHASE_BEATS);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/sva_pkg.sv
src/sva_ctrl.sv
src/sva_datapath.sv
src/synth_voice_allocator.sv
verif/synth_voice_allocator_tb.sv
